[rtl/sagp_pkg.sv]
// ----------------------------------------------------------------------------
// Sample average gamma pixel pack: shared package
// Field widths, register indexes and the gamma threshold table.
// ----------------------------------------------------------------------------
`default_nettype none

package sagp_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int MAX_SAMPLES = 1024;
	localparam int CH_W        = 16;
	localparam int COORD_W     = 13;
	localparam int SPP_W       = 11;
	localparam int LW_W        = 14;
	localparam int SUM_W       = 26;
	localparam int CNT_W       = 11;
	localparam int AVG_W       = FRAC_BITS + 1;
	localparam int ADDR_W      = 26;
	localparam int WORD_W      = 32;
	localparam int CFG_W       = 14;
	localparam int NUM_LANES   = 3;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [AVG_W-1:0] AVG_ONE = AVG_W'(1) << FRAC_BITS;
	localparam logic [7:0]       ALPHA   = 8'hff;

	// Configuration register indexes.
	localparam logic REG_SPP = 1'b0;
	localparam logic REG_LW  = 1'b1;

	typedef logic [AVG_W-1:0] gamma_tab_t [256];

	// Handshake from the merge logic to the channel lanes.
	typedef struct packed {
		logic start;
		logic ack;
	} lane_ctl_t;

	// Smallest average v with v^5 * 255^11 >= k^11 * 2^(5*FRAC_BITS).
	function automatic logic [AVG_W-1:0] gamma_threshold(input int k);
		logic [191:0] lhs;
		logic [191:0] rhs;
		logic [191:0] kp;
		int lo;
		int hi;
		int mid;
		kp = 192'd1;
		for (int i = 0; i < 11; i++) kp = kp * 192'(k);
		kp = kp << (5 * FRAC_BITS);
		lo = 0;
		hi = 1 << FRAC_BITS;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			lhs = 192'd1;
			for (int i = 0; i < 5; i++) lhs = lhs * 192'(mid);
			rhs = lhs;
			for (int i = 0; i < 11; i++) rhs = rhs * 192'd255;
			if (rhs >= kp) hi = mid;
			else lo = mid + 1;
		end
		return AVG_W'(lo);
	endfunction

	function automatic gamma_tab_t gamma_table();
		gamma_tab_t t;
		for (int k = 0; k < 256; k++) t[k] = gamma_threshold(k);
		return t;
	endfunction

	localparam gamma_tab_t GAMMA_T = gamma_table();

endpackage

`default_nettype wire

[rtl/sagp_lane.sv]
// ----------------------------------------------------------------------------
// Sample average gamma pixel pack: channel lane
// Divides one channel sum by the sample count one quotient bit per cycle,
// clamps to 1.0 and finds the gamma byte by an eight step threshold search.
// ----------------------------------------------------------------------------
`default_nettype none

module sagp_lane import sagp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lane_ctl_t        ctl,
	input  wire logic [SUM_W-1:0] sum,
	input  wire logic [CNT_W-1:0] count,
	output logic                  done,
	output logic [7:0]            gamma
);

	typedef enum logic [1:0] {L_IDLE, L_DIV, L_GAM, L_DONE} lane_state_t;

	lane_state_t      state_q;
	logic [SUM_W-1:0] dividend_q;
	logic [SUM_W-1:0] quot_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [4:0]       step_q;
	logic [AVG_W-1:0] avg_q;
	logic [7:0]       gam_q;
	logic [2:0]       bit_q;

	logic [CNT_W:0]   rem_sh;
	logic             ge;
	logic [CNT_W:0]   rem_nx;
	logic [SUM_W-1:0] quot_nx;
	logic [7:0]       trial;

	// One restoring division step.
	always_comb begin
		rem_sh  = {rem_q, dividend_q[SUM_W-1]};
		ge      = rem_sh >= {1'b0, cnt_q};
		rem_nx  = ge ? rem_sh - {1'b0, cnt_q} : rem_sh;
		quot_nx = {quot_q[SUM_W-2:0], ge};
		trial   = gam_q | (8'd1 << bit_q);
	end

	// Lane sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			step_q  <= '0;
			bit_q   <= '0;
			gam_q   <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						dividend_q <= sum;
						cnt_q      <= count;
						rem_q      <= '0;
						quot_q     <= '0;
						step_q     <= '0;
						state_q    <= L_DIV;
					end
				end
				L_DIV: begin
					dividend_q <= dividend_q << 1;
					rem_q      <= rem_nx[CNT_W-1:0];
					quot_q     <= quot_nx;
					step_q     <= step_q + 5'd1;
					if (step_q == 5'(SUM_W - 1)) begin
						avg_q   <= (quot_nx > SUM_W'(AVG_ONE)) ? AVG_ONE
							: quot_nx[AVG_W-1:0];
						gam_q   <= '0;
						bit_q   <= 3'd7;
						state_q <= L_GAM;
					end
				end
				L_GAM: begin
					if (GAMMA_T[trial] <= avg_q) gam_q <= trial;
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) state_q <= L_DONE;
				end
				L_DONE: begin
					if (ctl.ack) state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done  = (state_q == L_DONE);
	assign gamma = gam_q;

endmodule

`default_nettype wire

[rtl/sample_average_gamma_pixel_pack_core.sv]
// ----------------------------------------------------------------------------
// Sample average gamma pixel pack core
// Accumulates color samples per pixel, then resolves each channel in its own
// lane and packs the gamma corrected bytes with the pixel address.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Word
// s_axis    in   s_axis_tvalid / tready    red, green, blue, col, row
// m_axis    out  m_axis_tvalid / tready    pixel_address, pixel_word
// cfg       in   cfg_we                    cfg_index selects the register
//
// A sample that does not finish a pixel is taken without holding s_axis_tready low.
// A finishing sample holds s_axis_tready low while the lanes are started, divide
// the sums, run the gamma threshold search and load the output register.
// The input stalls while the lanes work and while a result waits on m_axis.
// Reset clears the sums, the sample count and all handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_average_gamma_pixel_pack_core import sagp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// red[15:0], green[31:16], blue[47:32], pixel_col[60:48],
	// pixel_row[73:61], zero[79:74]
	input  wire logic [79:0]      s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// pixel_address[25:0], pixel_word[57:26], zero[63:58]
	output logic [63:0]           m_axis_tdata,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic [SPP_W-1:0]   spp_q;
	logic [LW_W-1:0]    lw_q;
	logic [SUM_W-1:0]   sum_q [NUM_LANES];
	logic [SUM_W-1:0]   res_sum_q [NUM_LANES];
	logic [CNT_W-1:0]   seen_q;
	logic [CNT_W-1:0]   res_cnt_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               start_q;
	logic               busy_q;
	logic [63:0]        out_q;
	logic               out_valid_q;

	logic [CH_W-1:0]    chan [NUM_LANES];
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [CNT_W-1:0]   eff_cnt;
	logic [SUM_W:0]     add_w [NUM_LANES];
	logic [SUM_W-1:0]   add_sat [NUM_LANES];
	logic               accept;
	logic               finish;
	logic [NUM_LANES-1:0] lane_done;
	logic [7:0]         lane_gamma [NUM_LANES];
	lane_ctl_t          ctl;
	logic               out_free;

	// Unpack the input word, saturate the running sums and clamp the sample count.
	always_comb begin
		chan[0] = s_axis_tdata[15:0];
		chan[1] = s_axis_tdata[31:16];
		chan[2] = s_axis_tdata[47:32];
		col     = s_axis_tdata[60:48];
		row     = s_axis_tdata[73:61];
		for (int i = 0; i < NUM_LANES; i++) begin
			add_w[i]   = {1'b0, sum_q[i]} + (SUM_W + 1)'(chan[i]);
			add_sat[i] = add_w[i][SUM_W] ? SUM_MAX : add_w[i][SUM_W-1:0];
		end
		if (spp_q == '0) eff_cnt = CNT_W'(1);
		else if (spp_q > SPP_W'(MAX_SAMPLES)) eff_cnt = CNT_W'(MAX_SAMPLES);
		else eff_cnt = spp_q;
	end

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign finish        = (seen_q + CNT_W'(1)) >= eff_cnt;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign ctl.start     = start_q;
	assign ctl.ack       = busy_q && (&lane_done) && out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q <= SPP_W'(1);
			lw_q  <= LW_W'(1024);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPP: spp_q <= cfg_data[SPP_W-1:0];
				REG_LW:  lw_q  <= cfg_data[LW_W-1:0];
				default: ;
			endcase
		end
	end

	// Accumulation and hand-off to the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LANES; i++) sum_q[i] <= '0;
			seen_q  <= '0;
			start_q <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (accept) begin
				if (finish) begin
					for (int i = 0; i < NUM_LANES; i++) begin
						res_sum_q[i] <= add_sat[i];
						sum_q[i]     <= '0;
					end
					res_cnt_q <= eff_cnt;
					addr_q    <= ADDR_W'(row) * ADDR_W'(lw_q) + ADDR_W'(col);
					seen_q    <= '0;
					start_q   <= 1'b1;
					busy_q    <= 1'b1;
				end else begin
					for (int i = 0; i < NUM_LANES; i++) sum_q[i] <= add_sat[i];
					seen_q <= seen_q + CNT_W'(1);
				end
			end else if (ctl.ack) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Channel lanes: red, green, blue.
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		sagp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sum    (res_sum_q[g]),
			.count  (res_cnt_q),
			.done   (lane_done[g]),
			.gamma  (lane_gamma[g])
		);
	end

	// Merge the lane bytes into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.ack) begin
			out_q       <= {6'd0, ALPHA, lane_gamma[2], lane_gamma[1], lane_gamma[0], addr_q};
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
	// The lanes run in lockstep and finish together.
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_done) |-> (lane_done == '0 || NUM_LANES == 1))
		else $error("lanes out of step");

	// The count of samples seen for a pixel stays below MAX_SAMPLES.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q < CNT_W'(MAX_SAMPLES))
		else $error("sample count overran");

	// A lane start only follows a finishing sample.
	a_start_src: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> busy_q && $past(accept))
		else $error("lane start without finishing sample");

	// A presented result carries full alpha.
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q[57:50] == ALPHA)
		else $error("alpha byte wrong");
`endif

endmodule

`default_nettype wire
